// ===== src/lre_pkg.sv =====
`default_nettype none

package lre_pkg;

  // Stack sizing and arithmetic width
  localparam int STACK_DEPTH = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Token kinds
  localparam logic [2:0] TK_LPAREN = 3'd0;
  localparam logic [2:0] TK_RPAREN = 3'd1;
  localparam logic [2:0] TK_PLUS   = 3'd2;
  localparam logic [2:0] TK_TIMES  = 3'd3;
  localparam logic [2:0] TK_INT    = 3'd4;
  localparam logic [2:0] TK_END    = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_PENDING  = 2'd0;
  localparam logic [1:0] ST_ACCEPT   = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  // LR automaton states
  localparam logic [3:0] LS_START = 4'd0;  // start
  localparam logic [3:0] LS_EXPR  = 4'd1;  // E at start
  localparam logic [3:0] LS_LPAR  = 4'd2;  // after (
  localparam logic [3:0] LS_INT   = 4'd3;  // int shifted
  localparam logic [3:0] LS_PLUS  = 4'd4;  // E +
  localparam logic [3:0] LS_TIMES = 4'd5;  // E *
  localparam logic [3:0] LS_PAR_E = 4'd6;  // ( E
  localparam logic [3:0] LS_ADD_E = 4'd7;  // E + E
  localparam logic [3:0] LS_MUL_E = 4'd8;  // E * E
  localparam logic [3:0] LS_RPAR  = 4'd9;  // ( E )
  localparam logic [3:0] LS_BAD   = 4'd15;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_MUL = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [2:0]        token_kind;
    logic signed [31:0] token_value;
  } lre_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
  } lre_out_t;

  // Stack memory access: one write, one read per memory
  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [3:0]             wstate;
    logic [VALUE_WIDTH-1:0] wvalue;
    logic [ADDR_W-1:0]      raddr_s;
    logic [ADDR_W-1:0]      raddr_v;
  } stk_req_t;

  typedef struct packed {
    logic [3:0]             rstate;
    logic [VALUE_WIDTH-1:0] rvalue;
  } stk_rd_t;

  // Goto on nonterminal E
  function automatic logic [3:0] goto_on_expr(input logic [3:0] s);
    logic [3:0] g;
    case (s)
      LS_START: g = LS_EXPR;
      LS_LPAR:  g = LS_PAR_E;
      LS_PLUS:  g = LS_ADD_E;
      LS_TIMES: g = LS_MUL_E;
      default:  g = LS_BAD;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== src/lr_expression_evaluator.sv =====
`default_nettype none
// Steps: a token that only shifts is taken, decoded and its result registered.
// Each reduction adds a pick step and a stack read / ALU / goto step, and each
// run of reductions ends with a recheck of the new top before moving on.
// Throughput: one token in flight; the next is taken once the result is in
// the output register. A result waits there while the output is stalled.
// Reset: stack pointer set to one entry holding state 0; memories not cleared.

module lr_expression_evaluator (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             in_valid_i,
  output logic                   in_stall_o,
  input  wire  lre_pkg::lre_in_t in_data_i,
  output logic                   out_valid_o,
  input  wire  logic             out_stall_i,
  output lre_pkg::lre_out_t      out_data_o
);
  import lre_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_EXEC   = 4'b0100,
    S_FINISH = 4'b1000
  } fsm_e;

  typedef enum logic [1:0] {
    RED_INT = 2'd0,
    RED_ADD = 2'd1,
    RED_MUL = 2'd2,
    RED_PAR = 2'd3
  } red_e;

  fsm_e                   state_q, state_d;
  red_e                   red_q, red_d;
  logic [2:0]             kind_q, kind_d;
  logic [VALUE_WIDTH-1:0] tval_q, tval_d;
  logic [3:0]             top_s_q, top_s_d;
  logic [VALUE_WIDTH-1:0] top_v_q, top_v_d;
  logic [SP_W-1:0]        sp_q, sp_d;
  logic                   settle_q, settle_d;
  logic                   cont_q, cont_d;
  logic [1:0]             status_q, status_d;
  logic [31:0]            acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  lre_out_t               out_data_q, out_data_d;

  stk_req_t               stk_req;
  stk_rd_t                stk_rd;
  alu_op_e                alu_op;
  logic [VALUE_WIDTH-1:0] alu_y;

  logic                   push;
  logic                   push_settle;
  logic [3:0]             push_s;
  logic [VALUE_WIDTH-1:0] push_v;
  logic                   fin;
  logic [1:0]             fin_st;
  logic [3:0]             goto_s;
  logic                   slot_free;
  logic [SP_W-1:0]        sp_m1, sp_m2, sp_m3, sp_m4;

  lre_stack u_stack (
    .clk_i (clk_i),
    .req_i (stk_req),
    .rd_o  (stk_rd)
  );

  lre_alu u_alu (
    .op_i (alu_op),
    .a_i  (top_v_q),
    .b_i  (stk_rd.rvalue),
    .y_o  (alu_y)
  );

  assign sp_m1 = sp_q - SP_W'(1);
  assign sp_m2 = sp_q - SP_W'(2);
  assign sp_m3 = sp_q - SP_W'(3);
  assign sp_m4 = sp_q - SP_W'(4);

  // Stack reads are issued every cycle from the top state; used in EXEC
  always_comb begin
    stk_req.we      = 1'b0;
    stk_req.waddr   = sp_m1[ADDR_W-1:0];
    stk_req.wstate  = top_s_q;
    stk_req.wvalue  = top_v_q;
    stk_req.raddr_s = (top_s_q == LS_INT) ? sp_m2[ADDR_W-1:0] : sp_m4[ADDR_W-1:0];
    stk_req.raddr_v = (top_s_q == LS_RPAR) ? sp_m2[ADDR_W-1:0] : sp_m3[ADDR_W-1:0];
    if (push && (sp_q < SP_W'(STACK_DEPTH))) begin
      stk_req.we = 1'b1;
    end
  end

  assign alu_op    = (red_q == RED_MUL) ? ALU_MUL : ALU_ADD;
  assign goto_s    = goto_on_expr(stk_rd.rstate);
  assign slot_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    red_d       = red_q;
    kind_d      = kind_q;
    tval_d      = tval_q;
    top_s_d     = top_s_q;
    top_v_d     = top_v_q;
    sp_d        = sp_q;
    settle_d    = settle_q;
    cont_d      = cont_q;
    status_d    = status_q;
    acc_d       = acc_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    push        = 1'b0;
    push_settle = 1'b0;
    push_s      = LS_START;
    push_v      = '0;
    fin         = 1'b0;
    fin_st      = ST_PENDING;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = in_data_i.token_kind;
          tval_d   = VALUE_WIDTH'(in_data_i.token_value);
          settle_d = 1'b0;
          cont_d   = 1'b0;
          state_d  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (settle_q) begin
          // reductions that need no lookahead
          if (top_s_q == LS_INT) begin
            if (sp_q <= SP_W'(1)) begin
              fin = 1'b1; fin_st = ST_ERROR;
            end else begin
              red_d = RED_INT; state_d = S_EXEC;
            end
          end else if ((top_s_q == LS_MUL_E) || (top_s_q == LS_RPAR)) begin
            if (sp_q < SP_W'(4)) begin
              fin = 1'b1; fin_st = ST_ERROR;
            end else begin
              red_d   = (top_s_q == LS_MUL_E) ? RED_MUL : RED_PAR;
              state_d = S_EXEC;
            end
          end else if (cont_q) begin
            // back to the pending token after an E+E reduction
            settle_d = 1'b0;
            cont_d   = 1'b0;
          end else begin
            fin = 1'b1; fin_st = ST_PENDING;
          end
        end else if (kind_q > TK_END) begin
          fin = 1'b1; fin_st = ST_ERROR;
        end else begin
          case (top_s_q)
            LS_START, LS_LPAR, LS_PLUS, LS_TIMES: begin
              if (kind_q == TK_LPAREN) begin
                push = 1'b1; push_s = LS_LPAR;
              end else if (kind_q == TK_INT) begin
                push = 1'b1; push_s = LS_INT; push_v = tval_q; push_settle = 1'b1;
              end else begin
                fin = 1'b1; fin_st = ST_ERROR;
              end
            end
            LS_EXPR: begin
              if (kind_q == TK_PLUS) begin
                push = 1'b1; push_s = LS_PLUS;
              end else if (kind_q == TK_TIMES) begin
                push = 1'b1; push_s = LS_TIMES;
              end else if (kind_q == TK_END) begin
                fin = 1'b1; fin_st = ST_ACCEPT;
              end else begin
                fin = 1'b1; fin_st = ST_ERROR;
              end
            end
            LS_PAR_E: begin
              if (kind_q == TK_PLUS) begin
                push = 1'b1; push_s = LS_PLUS;
              end else if (kind_q == TK_TIMES) begin
                push = 1'b1; push_s = LS_TIMES;
              end else if (kind_q == TK_RPAREN) begin
                push = 1'b1; push_s = LS_RPAR; push_settle = 1'b1;
              end else begin
                fin = 1'b1; fin_st = ST_ERROR;
              end
            end
            LS_ADD_E: begin
              // times binds tighter: shift it, otherwise reduce the sum
              if (kind_q == TK_TIMES) begin
                push = 1'b1; push_s = LS_TIMES;
              end else if (sp_q < SP_W'(4)) begin
                fin = 1'b1; fin_st = ST_ERROR;
              end else begin
                red_d   = RED_ADD;
                cont_d  = 1'b1;
                state_d = S_EXEC;
              end
            end
            default: begin
              fin = 1'b1; fin_st = ST_ERROR;
            end
          endcase
        end
      end

      S_EXEC: begin
        // pop, goto on E, push the reduced value
        if (goto_s == LS_BAD) begin
          fin = 1'b1; fin_st = ST_ERROR;
        end else begin
          top_s_d = goto_s;
          case (red_q)
            RED_INT: top_v_d = top_v_q;
            RED_PAR: top_v_d = stk_rd.rvalue;
            default: top_v_d = alu_y;
          endcase
          sp_d     = (red_q == RED_INT) ? sp_q : sp_m2;
          settle_d = 1'b1;
          state_d  = S_DECIDE;
        end
      end

      S_FINISH: begin
        if (slot_free) begin
          out_data_d.status       = status_q;
          out_data_d.result_value = acc_q;
          out_valid_d             = 1'b1;
          state_d                 = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // shift
    if (push) begin
      if (sp_q >= SP_W'(STACK_DEPTH)) begin
        fin = 1'b1; fin_st = ST_OVERFLOW;
      end else begin
        top_s_d = push_s;
        top_v_d = push_v;
        sp_d    = sp_q + SP_W'(1);
        if (push_settle) begin
          settle_d = 1'b1;
        end else begin
          fin = 1'b1; fin_st = ST_PENDING;
        end
      end
    end

    // end of token: latch status, restart the stack unless pending
    if (fin) begin
      status_d = fin_st;
      acc_d    = (fin_st == ST_ACCEPT) ? 32'(top_v_q) : 32'd0;
      state_d  = S_FINISH;
      if (fin_st != ST_PENDING) begin
        top_s_d = LS_START;
        top_v_d = '0;
        sp_d    = SP_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_s_q     <= LS_START;
      top_v_q     <= '0;
      sp_q        <= SP_W'(1);
      settle_q    <= 1'b0;
      cont_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_s_q     <= top_s_d;
      top_v_q     <= top_v_d;
      sp_q        <= sp_d;
      settle_q    <= settle_d;
      cont_q      <= cont_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    red_q      <= red_d;
    kind_q     <= kind_d;
    tval_q     <= tval_d;
    status_q   <= status_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/lre_stack.sv =====
`default_nettype none

module lre_stack (
  input  wire                logic clk_i,
  input  wire  lre_pkg::stk_req_t req_i,
  output lre_pkg::stk_rd_t         rd_o
);
  import lre_pkg::*;

  logic [3:0]             state_mem [STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] value_mem [STACK_DEPTH];
  stk_rd_t                rd_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      state_mem[req_i.waddr] <= req_i.wstate;
      value_mem[req_i.waddr] <= req_i.wvalue;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rd_q.rstate <= state_mem[req_i.raddr_s];
    rd_q.rvalue <= value_mem[req_i.raddr_v];
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ===== src/lre_alu.sv =====
`default_nettype none

module lre_alu (
  input  wire  lre_pkg::alu_op_e               op_i,
  input  wire  logic [lre_pkg::VALUE_WIDTH-1:0] a_i,
  input  wire  logic [lre_pkg::VALUE_WIDTH-1:0] b_i,
  output logic [lre_pkg::VALUE_WIDTH-1:0]       y_o
);
  import lre_pkg::*;

  // Shared add / multiply, wrapping at the value width
  always_comb begin
    case (op_i)
      ALU_MUL: y_o = a_i * b_i;
      default: y_o = a_i + b_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/lr_expression_evaluator_tb.sv =====
`timescale 1ns / 100ps

module lr_expression_evaluator_tb;
  import lre_pkg::*;

  localparam int N_ITEMS     = 1320;
  localparam int QUIET_TAIL  = 100;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    lre_in_t tok;
    bit      drain;
  } pend_tok_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  lre_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lre_out_t out_data_o;

  pend_tok_t token_q[$];
  lre_out_t  pending_results[$];
  int        err_cnt   = 0;
  int        cyc_cnt   = 0;
  int        gap_cnt   = 0;
  int        stall_cnt = 0;
  logic      in_took   = 1'b0;
  bit        drain_next = 1'b0;

  // Parser shadow state
  logic [3:0]             lr_state[STACK_DEPTH];
  logic [VALUE_WIDTH-1:0] lr_value[STACK_DEPTH];
  int                     lr_sp;

  lr_expression_evaluator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------
  // Shift-reduce predictor
  // ---------------------------------------------------------------
  function automatic void lr_restart();
    lr_state[0] = LS_START;
    lr_value[0] = '0;
    lr_sp       = 1;
  endfunction

  function automatic logic [3:0] expr_goto(logic [3:0] s);
    case (s)
      LS_START: return LS_EXPR;
      LS_LPAR:  return LS_PAR_E;
      LS_PLUS:  return LS_ADD_E;
      LS_TIMES: return LS_MUL_E;
      default:  return LS_BAD;
    endcase
  endfunction

  function automatic logic [1:0] lr_push(logic [3:0] s, logic [VALUE_WIDTH-1:0] v);
    if (lr_sp >= STACK_DEPTH) return ST_OVERFLOW;
    lr_state[lr_sp] = s;
    lr_value[lr_sp] = v;
    lr_sp++;
    return ST_PENDING;
  endfunction

  // Pop n entries, then push the goto on E
  function automatic logic [1:0] lr_reduce(int n, logic [VALUE_WIDTH-1:0] v);
    logic [3:0] g;
    if (lr_sp <= n) return ST_ERROR;
    lr_sp -= n;
    g = expr_goto(lr_state[lr_sp-1]);
    if (g == LS_BAD) return ST_ERROR;
    return lr_push(g, v);
  endfunction

  // Reductions that need no lookahead: int, E*E, (E)
  function automatic logic [1:0] lr_settle();
    logic [1:0] st;
    logic [3:0] s;
    while (1) begin
      s = lr_state[lr_sp-1];
      if (s == LS_INT) begin
        st = lr_reduce(1, lr_value[lr_sp-1]);
      end else if (s == LS_MUL_E || s == LS_RPAR) begin
        if (lr_sp < 4) return ST_ERROR;
        if (s == LS_MUL_E) st = lr_reduce(3, lr_value[lr_sp-1] * lr_value[lr_sp-3]);
        else st = lr_reduce(3, lr_value[lr_sp-2]);
      end else begin
        return ST_PENDING;
      end
      if (st != ST_PENDING) return st;
    end
    return ST_ERROR;
  endfunction

  function automatic logic [1:0] lr_shift(logic [2:0] kind, logic [VALUE_WIDTH-1:0] tv,
                                          output logic [VALUE_WIDTH-1:0] acc);
    logic [1:0] st;
    logic [3:0] s;
    acc = '0;
    if (kind > TK_END) return ST_ERROR;
    while (1) begin
      s = lr_state[lr_sp-1];
      case (s)
        LS_START, LS_LPAR, LS_PLUS, LS_TIMES: begin
          if (kind == TK_LPAREN) return lr_push(LS_LPAR, '0);
          if (kind == TK_INT) begin
            st = lr_push(LS_INT, tv);
            return (st != ST_PENDING) ? st : lr_settle();
          end
          return ST_ERROR;
        end
        LS_EXPR: begin
          if (kind == TK_PLUS) return lr_push(LS_PLUS, '0);
          if (kind == TK_TIMES) return lr_push(LS_TIMES, '0);
          if (kind == TK_END) begin
            acc = lr_value[lr_sp-1];
            return ST_ACCEPT;
          end
          return ST_ERROR;
        end
        LS_PAR_E: begin
          if (kind == TK_PLUS) return lr_push(LS_PLUS, '0);
          if (kind == TK_TIMES) return lr_push(LS_TIMES, '0);
          if (kind == TK_RPAREN) begin
            st = lr_push(LS_RPAR, '0);
            return (st != ST_PENDING) ? st : lr_settle();
          end
          return ST_ERROR;
        end
        LS_ADD_E: begin
          // times binds tighter: shift it, otherwise fold the sum
          if (kind == TK_TIMES) return lr_push(LS_TIMES, '0);
          if (lr_sp < 4) return ST_ERROR;
          st = lr_reduce(3, lr_value[lr_sp-1] + lr_value[lr_sp-3]);
          if (st == ST_PENDING) st = lr_settle();
          if (st != ST_PENDING) return st;
        end
        default: return ST_ERROR;
      endcase
    end
    return ST_ERROR;
  endfunction

  function automatic lre_out_t eval_token(lre_in_t t);
    lre_out_t               r;
    logic [1:0]             st;
    logic [VALUE_WIDTH-1:0] acc;
    st = lr_shift(t.token_kind, t.token_value, acc);
    if (st != ST_PENDING) lr_restart();
    r.status       = st;
    r.result_value = (st == ST_ACCEPT) ? acc : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Token stream generation
  // ---------------------------------------------------------------
  task automatic add_tok(logic [2:0] k, logic [31:0] v);
    pend_tok_t p;
    p.tok.token_kind  = k;
    p.tok.token_value = v;
    p.drain           = drain_next;
    drain_next        = 1'b0;
    token_q.push_back(p);
  endtask

  function automatic logic [31:0] rand_lit();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 9);
      3:       return 32'd0 - $urandom_range(1, 9);
      default: return $urandom;
    endcase
  endfunction

  task automatic gen_term(int lvl);
    if (lvl < 4 && $urandom_range(0, 3) == 0) begin
      add_tok(TK_LPAREN, $urandom);
      gen_expr(lvl + 1);
      add_tok(TK_RPAREN, $urandom);
    end else begin
      add_tok(TK_INT, rand_lit());
    end
  endtask

  task automatic gen_expr(int lvl);
    int n;
    n = $urandom_range(0, 3);
    gen_term(lvl);
    repeat (n) begin
      add_tok($urandom_range(0, 1) ? TK_PLUS : TK_TIMES, $urandom);
      gen_term(lvl);
    end
  endtask

  // Idle stretches alternate with calm ones; none in the tail
  function automatic bit idling_allowed();
    return token_q.size() >= QUIET_TAIL && ((token_q.size() / 128) % 3 != 1);
  endfunction

  // ---------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------
  always @(negedge clk_i) begin : drive_in
    logic    vld;
    lre_in_t dat;
    vld = in_valid_i;
    dat = in_data_i;
    if (!rst_ni) begin
      vld = 1'b0;
    end else begin
      if (vld && in_took) begin
        vld = 1'b0;
        if (idling_allowed() && $urandom_range(0, 4) == 0) gap_cnt = $urandom_range(1, 6);
      end
      if (!vld) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (token_q.size() > 0 &&
                     !(token_q[0].drain && pending_results.size() > 0)) begin
          dat = token_q[0].tok;
          token_q.pop_front();
          vld = 1'b1;
        end
      end
    end
    in_valid_i <= vld;
    in_data_i  <= dat;
  end

  // Output stall bursts
  always @(negedge clk_i) begin : drive_stall
    logic stl;
    stl = 1'b0;
    if (rst_ni && idling_allowed()) begin
      if (stall_cnt > 0) begin
        stl = 1'b1;
        stall_cnt--;
      end else if ($urandom_range(0, 5) == 0) begin
        stl       = 1'b1;
        stall_cnt = $urandom_range(1, 6) - 1;
      end
    end
    out_stall_i <= stl;
  end

  // ---------------------------------------------------------------
  // Monitor: check results, then predict newly taken items
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lre_out_t want;
    in_took <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d value %0d", $time,
                   out_data_o.status, out_data_o.result_value);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, out_data_o.status);
            err_cnt++;
          end
          if (out_data_o.result_value !== want.result_value) begin
            $display("%0t: result_value mismatch: expected %0d actual %0d", $time,
                     want.result_value, out_data_o.result_value);
            err_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) pending_results.push_back(eval_token(in_data_i));
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("[lr_expression_evaluator] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------
  initial begin : stimulus
    int r;
    int k;
    int n;
    lr_restart();

    // Directed: wrap on add and multiply, precedence, parentheses
    add_tok(TK_INT, 32'h7fff_ffff);
    add_tok(TK_PLUS, $urandom);
    add_tok(TK_INT, 32'd2);
    add_tok(TK_TIMES, $urandom);
    add_tok(TK_LPAREN, $urandom);
    add_tok(TK_INT, 32'h8000_0000);
    add_tok(TK_PLUS, $urandom);
    add_tok(TK_INT, 32'hffff_ffff);
    add_tok(TK_RPAREN, $urandom);
    add_tok(TK_END, $urandom);
    // empty expression, stray close paren, unknown kinds
    add_tok(TK_END, $urandom);
    add_tok(TK_RPAREN, $urandom);
    add_tok(3'd6, $urandom);
    add_tok(3'd7, $urandom);
    // incomplete sum, two ints in a row, plain literal
    add_tok(TK_INT, 32'd5);
    add_tok(TK_PLUS, $urandom);
    add_tok(TK_END, $urandom);
    add_tok(TK_INT, 32'd0);
    add_tok(TK_INT, 32'd0);
    add_tok(TK_INT, 32'h8000_0000);
    add_tok(TK_END, $urandom);

    // Random: mostly well-formed expressions, some broken, some deep nests
    drain_next = 1'b1;
    while (token_q.size() < N_ITEMS) begin
      if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
      r = $urandom_range(0, 19);
      if (r < 15) begin
        gen_expr(0);
      end else if (r < 18) begin
        n = $urandom_range(1, 8);
        repeat (n) add_tok(3'($urandom_range(0, 7)), rand_lit());
      end else begin
        // nesting near the stack depth; the deepest ones overflow
        k = $urandom_range(59, 64);
        repeat (k) add_tok(TK_LPAREN, $urandom);
        gen_expr(4);
        repeat (k) add_tok(TK_RPAREN, $urandom);
      end
      add_tok(TK_END, $urandom);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (token_q.size() > 0 || in_valid_i || pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[lr_expression_evaluator] OK");
    end else begin
      $display("[lr_expression_evaluator] ERROR");
    end
    $finish;
  end

endmodule
